@@ rtl/assert_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KSE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication.
`define KSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

@@ rtl/kse_pkg.sv @@
package kse_pkg;

  localparam int KEY_TABLE_SIZE_DEF = 256;
  localparam int COUNT_WIDTH_DEF    = 32;
  localparam int TIME_WIDTH_DEF     = 48;

  localparam int KEY_CODE_W  = 10;
  localparam int KEY_VALUE_W = 2;
  localparam int GAP_LIMIT_W = 26;
  localparam int RATE_W      = 26;
  localparam int OUT_CODE_W  = 8;
  localparam int OUT_COUNT_W = 32;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [GAP_LIMIT_W-1:0] GAP_LIMIT_RESET = 26'd5000000;
  localparam logic [RATE_W-1:0]      USEC_PER_MINUTE = 26'd60000000;

  localparam logic CMD_KEY   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [KEY_VALUE_W-1:0] KV_RELEASE = 2'd0;
  localparam logic [KEY_VALUE_W-1:0] KV_PRESS   = 2'd1;

  localparam logic [KEY_CODE_W-1:0] CODE_CTRL_L  = 10'd29;
  localparam logic [KEY_CODE_W-1:0] CODE_CTRL_R  = 10'd97;
  localparam logic [KEY_CODE_W-1:0] CODE_SHIFT_L = 10'd42;
  localparam logic [KEY_CODE_W-1:0] CODE_SHIFT_R = 10'd54;
  localparam logic [KEY_CODE_W-1:0] CODE_ALT_L   = 10'd56;
  localparam logic [KEY_CODE_W-1:0] CODE_ALT_R   = 10'd100;

  // register index, taken from paddr[2]
  localparam logic REG_GAP_LIMIT = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY_RD,
    ST_KEY_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_KPM_GO,
    ST_KPM_WAIT,
    ST_OUT
  } kse_state_t;

  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic idx_step;
    logic scan_rd;
    logic key_rd;
    logic key_wr;
    logic div_avg;
    logic div_kpm;
    logic avg_load;
    logic kpm_load;
    logic res_load;
  } kse_cmd_t;

  typedef struct packed {
    logic in_query;
    logic in_key;
    logic is_press;
    logic idx_last;
    logic tally_gt1;
    logic div_done;
    logic quo_zero;
  } kse_sts_t;

endpackage

@@ rtl/kse_div.sv @@
module kse_div
  import kse_pkg::*;
#(
  parameter int DIVIDEND_W = TIME_WIDTH_DEF,
  parameter int DIVISOR_W  = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dv;
  logic [DIVISOR_W:0]   sh;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign sh   = {rem, quotient[DIVIDEND_W-1]};
  assign ge   = sh >= {1'b0, dv};
  assign diff = sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dv       <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DIVISOR_W-1:0] : sh[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

@@ rtl/kse_ctrl.sv @@
module kse_ctrl
  import kse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  output logic     result_valid,
  input  logic     result_ready,
  input  kse_sts_t sts,
  output kse_cmd_t cmd
);

  kse_state_t state, state_next;
  logic       result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    cmd               = '0;
    item_ready        = 1'b0;
    result_valid_next = result_valid && !result_ready;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.idx_step = 1'b1;
        if (sts.idx_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_query) state_next = ST_SCAN;
          else if (sts.in_key) state_next = ST_KEY_RD;
        end
      end
      ST_KEY_RD: begin
        cmd.key_rd = 1'b1;
        state_next = sts.is_press ? ST_KEY_WR : ST_IDLE;
      end
      ST_KEY_WR: begin
        cmd.key_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd  = 1'b1;
        cmd.idx_step = 1'b1;
        if (sts.idx_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = sts.tally_gt1 ? ST_AVG_GO : ST_OUT;
      end
      ST_AVG_GO: begin
        cmd.div_avg = 1'b1;
        state_next  = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          state_next   = sts.quo_zero ? ST_OUT : ST_KPM_GO;
        end
      end
      ST_KPM_GO: begin
        cmd.div_kpm = 1'b1;
        state_next  = ST_KPM_WAIT;
      end
      ST_KPM_WAIT: begin
        if (sts.div_done) begin
          cmd.kpm_load = 1'b1;
          state_next   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!result_valid || result_ready) begin
          cmd.res_load      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/kse_datapath.sv @@
module kse_datapath
  import kse_pkg::*;
#(
  parameter int KEY_TABLE_SIZE = KEY_TABLE_SIZE_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH     = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kse_cmd_t               cmd,
  output kse_sts_t               sts,
  input  logic [GAP_LIMIT_W-1:0] gap_limit,
  input  logic                   command,
  input  logic                   event_is_key,
  input  logic [KEY_CODE_W-1:0]  key_code,
  input  logic [KEY_VALUE_W-1:0] key_value,
  input  logic [TIME_WIDTH-1:0]  timestamp_us,
  output logic [OUT_COUNT_W-1:0] total_presses,
  output logic [RATE_W-1:0]      keys_per_minute,
  output logic [RATE_W-1:0]      avg_interval_us,
  output logic [OUT_COUNT_W-1:0] hotkey_total,
  output logic [OUT_CODE_W-1:0]  first_code,
  output logic [OUT_COUNT_W-1:0] first_count,
  output logic [OUT_CODE_W-1:0]  second_code,
  output logic [OUT_COUNT_W-1:0] second_count,
  output logic [OUT_CODE_W-1:0]  third_code,
  output logic [OUT_COUNT_W-1:0] third_count
);

  localparam int KW    = $clog2(KEY_TABLE_SIZE);
  localparam int DIV_W = (COUNT_WIDTH > RATE_W) ? COUNT_WIDTH : RATE_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + CNT_ONE;
  endfunction

  logic [KEY_CODE_W-1:0]  code_q;
  logic [KEY_VALUE_W-1:0] value_q;
  logic [TIME_WIDTH-1:0]  ts_q;

  logic                   ctrl_held;
  logic                   alt_held;
  logic [COUNT_WIDTH-1:0] press_total;
  logic [COUNT_WIDTH-1:0] hotkey_tally;
  logic [COUNT_WIDTH-1:0] interval_tally;
  logic [TIME_WIDTH-1:0]  prev_stamp;
  logic [TIME_WIDTH-1:0]  interval_sum;
  logic [TIME_WIDTH-1:0]  gap;

  logic [KW-1:0]          idx;
  logic                   rd_vld;
  logic [KW-1:0]          rd_code;

  logic [COUNT_WIDTH-1:0] hist [KEY_TABLE_SIZE];
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   mem_we;
  logic [KW-1:0]          mem_waddr;
  logic [KW-1:0]          mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  logic [COUNT_WIDTH-1:0] c0, c1, c2;
  logic [KW-1:0]          k0, k1, k2;
  logic [RATE_W-1:0]      avg;
  logic [RATE_W-1:0]      kpm;

  logic                   in_table;
  logic                   is_mod;
  logic                   gap_ok;
  logic [TIME_WIDTH:0]    sum_add;
  logic [TIME_WIDTH-1:0]  sum_sat;

  logic                   div_start;
  logic [TIME_WIDTH-1:0]  div_dividend;
  logic [DIV_W-1:0]       div_divisor;
  logic                   div_done;
  logic [TIME_WIDTH-1:0]  div_quo;

  assign in_table = {1'b0, code_q} < (KEY_CODE_W + 1)'(KEY_TABLE_SIZE);
  assign is_mod   = code_q inside {CODE_CTRL_L, CODE_CTRL_R, CODE_SHIFT_L,
                                   CODE_SHIFT_R, CODE_ALT_L, CODE_ALT_R};
  assign gap_ok   = (gap != '0) && (gap < TIME_WIDTH'(gap_limit)) && !(&interval_tally);
  assign sum_add  = {1'b0, interval_sum} + {1'b0, gap};
  assign sum_sat  = sum_add[TIME_WIDTH] ? '1 : sum_add[TIME_WIDTH-1:0];

  assign sts.in_query  = command == CMD_QUERY;
  assign sts.in_key    = event_is_key;
  assign sts.is_press  = value_q == KV_PRESS;
  assign sts.idx_last  = idx == KW'(KEY_TABLE_SIZE - 1);
  assign sts.tally_gt1 = interval_tally > CNT_ONE;
  assign sts.div_done  = div_done;
  assign sts.quo_zero  = div_quo == '0;

  assign mem_we    = cmd.clear_wr || (cmd.key_wr && in_table);
  assign mem_waddr = cmd.clear_wr ? idx : code_q[KW-1:0];
  assign mem_wdata = cmd.clear_wr ? '0 : sat_inc(rdata);
  assign mem_raddr = cmd.scan_rd ? idx : code_q[KW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) hist[mem_waddr] <= mem_wdata;
    rdata <= hist[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.idx_step) idx <= sts.idx_last ? '0 : idx + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_code <= idx;
    if (cmd.accept) begin
      code_q  <= key_code;
      value_q <= key_value;
      ts_q    <= timestamp_us;
    end
    if (cmd.key_rd) gap <= ts_q - prev_stamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_held      <= 1'b0;
      alt_held       <= 1'b0;
      press_total    <= '0;
      hotkey_tally   <= '0;
      interval_tally <= '0;
      interval_sum   <= '0;
      prev_stamp     <= '0;
    end else begin
      if (cmd.key_rd) begin
        if (code_q == CODE_CTRL_L || code_q == CODE_CTRL_R)
          ctrl_held <= value_q != KV_RELEASE;
        if (code_q == CODE_ALT_L || code_q == CODE_ALT_R)
          alt_held <= value_q != KV_RELEASE;
      end
      if (cmd.key_wr) begin
        press_total <= sat_inc(press_total);
        prev_stamp  <= ts_q;
        if ((ctrl_held || alt_held) && !is_mod) hotkey_tally <= sat_inc(hotkey_tally);
        if (interval_tally == '0) begin
          interval_tally <= CNT_ONE;
        end else if (gap_ok) begin
          interval_tally <= interval_tally + CNT_ONE;
          interval_sum   <= sum_sat;
        end
      end
    end
  end

  // top three, strict compare keeps the lowest code on ties
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.in_query) begin
      c0  <= '0;
      c1  <= '0;
      c2  <= '0;
      k0  <= '0;
      k1  <= '0;
      k2  <= '0;
      avg <= '0;
      kpm <= '0;
    end else begin
      if (rd_vld) begin
        if (rdata > c0) begin
          c2 <= c1;
          k2 <= k1;
          c1 <= c0;
          k1 <= k0;
          c0 <= rdata;
          k0 <= rd_code;
        end else if (rdata > c1) begin
          c2 <= c1;
          k2 <= k1;
          c1 <= rdata;
          k1 <= rd_code;
        end else if (rdata > c2) begin
          c2 <= rdata;
          k2 <= rd_code;
        end
      end
      if (cmd.avg_load)
        avg <= (|div_quo[TIME_WIDTH-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];
      if (cmd.kpm_load) kpm <= div_quo[RATE_W-1:0];
    end
  end

  assign div_start    = cmd.div_avg || cmd.div_kpm;
  assign div_dividend = cmd.div_kpm ? TIME_WIDTH'(USEC_PER_MINUTE) : interval_sum;
  assign div_divisor  = cmd.div_kpm ? DIV_W'(avg) : DIV_W'(interval_tally - CNT_ONE);

  kse_div #(
    .DIVIDEND_W(TIME_WIDTH),
    .DIVISOR_W (DIV_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      total_presses   <= OUT_COUNT_W'(press_total);
      hotkey_total    <= OUT_COUNT_W'(hotkey_tally);
      avg_interval_us <= avg;
      keys_per_minute <= kpm;
      first_code      <= OUT_CODE_W'(k0);
      first_count     <= OUT_COUNT_W'(c0);
      second_code     <= OUT_CODE_W'(k1);
      second_count    <= OUT_COUNT_W'(c1);
      third_code      <= OUT_CODE_W'(k2);
      third_count     <= OUT_COUNT_W'(c2);
    end
  end

endmodule

@@ rtl/keypress_statistics_engine.sv @@
// Key event: non-key items stay idle, release/repeat pass ST_KEY_RD, a press also ST_KEY_WR.
// Query: from accept, ST_SCAN walks the single-read-port histogram, then the
// one-bit-per-cycle shared divider forms the mean and keys per minute (skipped when
// no mean exists), plus any wait on result_ready before the result beat.
// A new item is taken while an earlier result still waits on the output.
// rst is synchronous; after it a pass zeroes the histogram with item_ready low,
// APB writes taken throughout.
module keypress_statistics_engine
  import kse_pkg::*;
#(
  parameter int KEY_TABLE_SIZE = KEY_TABLE_SIZE_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int TIME_WIDTH     = TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   command,
  input  logic                   event_is_key,
  input  logic [KEY_CODE_W-1:0]  key_code,
  input  logic [KEY_VALUE_W-1:0] key_value,
  input  logic [TIME_WIDTH-1:0]  timestamp_us,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [OUT_COUNT_W-1:0] total_presses,
  output logic [RATE_W-1:0]      keys_per_minute,
  output logic [RATE_W-1:0]      avg_interval_us,
  output logic [OUT_COUNT_W-1:0] hotkey_total,
  output logic [OUT_CODE_W-1:0]  first_code,
  output logic [OUT_COUNT_W-1:0] first_count,
  output logic [OUT_CODE_W-1:0]  second_code,
  output logic [OUT_COUNT_W-1:0] second_count,
  output logic [OUT_CODE_W-1:0]  third_code,
  output logic [OUT_COUNT_W-1:0] third_count,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [GAP_LIMIT_W-1:0] gap_limit;
  kse_cmd_t               cmd;
  kse_sts_t               sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAP_LIMIT) ? APB_DATA_W'(gap_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAP_LIMIT) begin
      gap_limit <= pwdata[GAP_LIMIT_W-1:0];
    end
  end

  kse_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  kse_datapath #(
    .KEY_TABLE_SIZE(KEY_TABLE_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .gap_limit      (gap_limit),
    .command        (command),
    .event_is_key   (event_is_key),
    .key_code       (key_code),
    .key_value      (key_value),
    .timestamp_us   (timestamp_us),
    .total_presses  (total_presses),
    .keys_per_minute(keys_per_minute),
    .avg_interval_us(avg_interval_us),
    .hotkey_total   (hotkey_total),
    .first_code     (first_code),
    .first_count    (first_count),
    .second_code    (second_code),
    .second_count   (second_count),
    .third_code     (third_code),
    .third_count    (third_count)
  );

endmodule

@@ rtl/kse_checker.sv @@
`include "assert_macros.svh"

module kse_checker
  import kse_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_ready,
  input logic                   command,
  input logic                   result_valid,
  input logic                   result_ready,
  input logic [RATE_W-1:0]      keys_per_minute,
  input logic [RATE_W-1:0]      avg_interval_us,
  input logic [OUT_COUNT_W-1:0] first_count,
  input logic [OUT_COUNT_W-1:0] second_count,
  input logic [OUT_COUNT_W-1:0] third_count
);

  `KSE_ASSERT_NEXT(a_query_blocks_intake, clk, rst, item_valid && item_ready && command == CMD_QUERY, !item_ready)
  `KSE_ASSERT_NOW(a_rank_order, clk, rst, result_valid, first_count >= second_count && second_count >= third_count)
  `KSE_ASSERT_NOW(a_rate_needs_mean, clk, rst, result_valid && keys_per_minute != '0, avg_interval_us != '0)
  `KSE_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && !result_ready, result_valid && $stable(first_count))

endmodule

bind keypress_statistics_engine kse_checker u_kse_checker (.*);

@@ tb/tb_keypress_statistics_engine.sv @@
`timescale 1ns / 1ps

module tb_keypress_statistics_engine;
  import kse_pkg::*;

  localparam int TABLE_DEPTH = KEY_TABLE_SIZE_DEF;
  localparam int STAMP_W = TIME_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 150;
  localparam logic [KEY_VALUE_W-1:0] KV_REPEAT = 2'd2;
  localparam logic [KEY_VALUE_W-1:0] KV_SPARE = 2'd3;
  localparam logic [APB_ADDR_W-1:0] GAP_LIMIT_ADDR = {REG_GAP_LIMIT, 2'b00};
  localparam logic [GAP_LIMIT_W-1:0] GAP_LIMIT_MAX = '1;

  typedef struct packed {
    logic                   command;
    logic                   is_key;
    logic [KEY_CODE_W-1:0]  code;
    logic [KEY_VALUE_W-1:0] value;
    logic [STAMP_W-1:0]     stamp;
  } key_item_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] total;
    logic [RATE_W-1:0]      kpm;
    logic [RATE_W-1:0]      mean;
    logic [OUT_COUNT_W-1:0] hotkeys;
    logic [OUT_CODE_W-1:0]  code1;
    logic [OUT_COUNT_W-1:0] count1;
    logic [OUT_CODE_W-1:0]  code2;
    logic [OUT_COUNT_W-1:0] count2;
    logic [OUT_CODE_W-1:0]  code3;
    logic [OUT_COUNT_W-1:0] count3;
  } stats_report_t;

  class typing_stats_tracker;
    bit [GAP_LIMIT_W-1:0] gap_limit;
    bit [OUT_COUNT_W-1:0] press_bins [TABLE_DEPTH];
    bit [OUT_COUNT_W-1:0] presses;
    bit [OUT_COUNT_W-1:0] hotkeys;
    bit [OUT_COUNT_W-1:0] gap_tally;
    bit [STAMP_W-1:0]     last_stamp;
    bit [STAMP_W-1:0]     gap_sum;
    bit                   ctrl_on;
    bit                   alt_on;
    stats_report_t        pending_reports [$];
    int                   errors;

    function new();
      gap_limit = GAP_LIMIT_RESET;
      foreach (press_bins[i]) press_bins[i] = '0;
      presses = '0;
      hotkeys = '0;
      gap_tally = '0;
      last_stamp = '0;
      gap_sum = '0;
      ctrl_on = 1'b0;
      alt_on = 1'b0;
      errors = 0;
    endfunction

    function void set_gap_limit(bit [APB_DATA_W-1:0] word);
      gap_limit = word[GAP_LIMIT_W-1:0];
    endfunction

    function bit [OUT_COUNT_W-1:0] bump(bit [OUT_COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function bit is_modifier(bit [KEY_CODE_W-1:0] code);
      return code == CODE_CTRL_L || code == CODE_CTRL_R || code == CODE_SHIFT_L ||
             code == CODE_SHIFT_R || code == CODE_ALT_L || code == CODE_ALT_R;
    endfunction

    function stats_report_t build_report();
      stats_report_t r;
      bit [STAMP_W-1:0] avg;
      bit taken [TABLE_DEPTH];
      bit [OUT_COUNT_W-1:0] best;
      int best_i;
      bit [OUT_CODE_W-1:0] rank_code [3];
      bit [OUT_COUNT_W-1:0] rank_count [3];
      r = '0;
      if (gap_tally > 1) begin
        avg = gap_sum / (gap_tally - 1'b1);
        if (avg > GAP_LIMIT_MAX) avg = GAP_LIMIT_MAX;
        r.mean = avg[RATE_W-1:0];
        if (avg != 0) r.kpm = USEC_PER_MINUTE / avg[RATE_W-1:0];
      end
      r.total = presses;
      r.hotkeys = hotkeys;
      foreach (taken[i]) taken[i] = 1'b0;
      for (int k = 0; k < 3; k++) begin
        best = '0;
        best_i = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!taken[i] && press_bins[i] > best) begin
            best = press_bins[i];
            best_i = i;
          end
        end
        rank_code[k] = '0;
        rank_count[k] = '0;
        if (best_i >= 0) begin
          taken[best_i] = 1'b1;
          rank_code[k] = best_i[OUT_CODE_W-1:0];
          rank_count[k] = best;
        end
      end
      r.code1 = rank_code[0];
      r.count1 = rank_count[0];
      r.code2 = rank_code[1];
      r.count2 = rank_count[1];
      r.code3 = rank_code[2];
      r.count3 = rank_count[2];
      return r;
    endfunction

    function void take_item(key_item_t it);
      bit [STAMP_W-1:0] gap;
      bit [STAMP_W:0] wide_sum;
      if (it.command == CMD_QUERY) begin
        pending_reports.push_back(build_report());
        return;
      end
      if (!it.is_key) return;
      if (it.code == CODE_CTRL_L || it.code == CODE_CTRL_R) ctrl_on = (it.value != KV_RELEASE);
      if (it.code == CODE_ALT_L || it.code == CODE_ALT_R) alt_on = (it.value != KV_RELEASE);
      if (it.value != KV_PRESS) return;
      if (it.code < TABLE_DEPTH) press_bins[it.code[7:0]] = bump(press_bins[it.code[7:0]]);
      presses = bump(presses);
      if (gap_tally != 0) begin
        gap = it.stamp - last_stamp;
        if (gap != 0 && gap < gap_limit && gap_tally != '1) begin
          wide_sum = {1'b0, gap_sum} + gap;
          gap_sum = wide_sum[STAMP_W] ? '1 : wide_sum[STAMP_W-1:0];
          gap_tally = gap_tally + 1'b1;
        end
      end else begin
        gap_tally = 1;
      end
      last_stamp = it.stamp;
      if ((ctrl_on || alt_on) && !is_modifier(it.code)) hotkeys = bump(hotkeys);
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void match_report(stats_report_t got);
      stats_report_t want;
      if (pending_reports.size() == 0) begin
        $error("stats beat with no query outstanding");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      check_field("total_presses", want.total, got.total);
      check_field("keys_per_minute", want.kpm, got.kpm);
      check_field("avg_interval_us", want.mean, got.mean);
      check_field("hotkey_total", want.hotkeys, got.hotkeys);
      check_field("first_code", want.code1, got.code1);
      check_field("first_count", want.count1, got.count1);
      check_field("second_code", want.code2, got.code2);
      check_field("second_count", want.count2, got.count2);
      check_field("third_code", want.code3, got.code3);
      check_field("third_count", want.count3, got.count3);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  logic                   command = CMD_KEY;
  logic                   event_is_key = 1'b0;
  logic [KEY_CODE_W-1:0]  key_code = '0;
  logic [KEY_VALUE_W-1:0] key_value = '0;
  logic [STAMP_W-1:0]     timestamp_us = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [OUT_COUNT_W-1:0] total_presses;
  logic [RATE_W-1:0]      keys_per_minute;
  logic [RATE_W-1:0]      avg_interval_us;
  logic [OUT_COUNT_W-1:0] hotkey_total;
  logic [OUT_CODE_W-1:0]  first_code;
  logic [OUT_COUNT_W-1:0] first_count;
  logic [OUT_CODE_W-1:0]  second_code;
  logic [OUT_COUNT_W-1:0] second_count;
  logic [OUT_CODE_W-1:0]  third_code;
  logic [OUT_COUNT_W-1:0] third_count;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  typing_stats_tracker model;
  bit steady = 1'b0;
  int rx_hold = 0;
  bit [STAMP_W-1:0] now_us = '0;
  bit [KEY_CODE_W-1:0] hot_codes [6] = '{10'd0, 10'd1, 10'd2, 10'd17, 10'd30, 10'd255};
  bit [KEY_CODE_W-1:0] mod_codes [6] = '{CODE_CTRL_L, CODE_CTRL_R, CODE_SHIFT_L,
                                         CODE_SHIFT_R, CODE_ALT_L, CODE_ALT_R};

  keypress_statistics_engine u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int draw_pause();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      result_ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 2) == 0) begin
      rx_hold = draw_pause();
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      model.match_report('{total: total_presses, kpm: keys_per_minute, mean: avg_interval_us,
                           hotkeys: hotkey_total, code1: first_code, count1: first_count,
                           code2: second_code, count2: second_count, code3: third_code,
                           count3: third_count});
    end
  end

  task automatic send_item(input key_item_t it);
    item_valid   <= 1'b1;
    command      <= it.command;
    event_is_key <= it.is_key;
    key_code     <= it.code;
    key_value    <= it.value;
    timestamp_us <= it.stamp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    model.take_item(it);
    @(negedge clk);
  endtask

  task automatic pace();
    int n;
    n = steady ? 0 : draw_pause();
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic key_beat(input bit [KEY_CODE_W-1:0] code, input bit [KEY_VALUE_W-1:0] value,
                          input bit [STAMP_W-1:0] stamp);
    send_item('{command: CMD_KEY, is_key: 1'b1, code: code, value: value, stamp: stamp});
    pace();
  endtask

  task automatic query_beat();
    send_item('{command: CMD_QUERY, is_key: 1'($urandom()),
                code: KEY_CODE_W'($urandom_range(0, 767)),
                value: 2'($urandom()), stamp: STAMP_W'({$urandom(), $urandom()})});
    pace();
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (model.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_gap_limit(input bit [APB_DATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAP_LIMIT_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    model.set_gap_limit(word);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic bit [STAMP_W-1:0] next_stamp();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) now_us = now_us + STAMP_W'($urandom_range(20000, 400000));
    else if (pick < 78) now_us = now_us;
    else if (pick < 86)
      now_us = now_us + STAMP_W'(model.gap_limit) + STAMP_W'($urandom_range(0, 2)) -
               STAMP_W'(1);
    else if (pick < 93) now_us = now_us + STAMP_W'($urandom_range(0, 32'h0FFF_FFFF));
    else now_us = STAMP_W'({$urandom(), $urandom()});
    return now_us;
  endfunction

  task automatic run_typing(input int count);
    key_item_t it;
    int done;
    int pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      it.command = CMD_KEY;
      it.is_key = 1'b1;
      it.code = KEY_CODE_W'($urandom_range(0, 767));
      it.value = 2'($urandom());
      it.stamp = STAMP_W'({$urandom(), $urandom()});
      if (pick < 8) begin
        it.command = CMD_QUERY;
        it.is_key = 1'($urandom());
      end else if (pick < 13) begin
        it.is_key = 1'b0;
      end else if (pick < 95) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) it.code = hot_codes[$urandom_range(0, 5)];
        else if (pick < 60) it.code = mod_codes[$urandom_range(0, 5)];
        else if (pick < 85) it.code = KEY_CODE_W'($urandom_range(0, TABLE_DEPTH - 1));
        else it.code = KEY_CODE_W'($urandom_range(TABLE_DEPTH, 767));
        pick = $urandom_range(0, 99);
        if (pick < 65) it.value = KV_PRESS;
        else if (pick < 85) it.value = KV_RELEASE;
        else if (pick < 95) it.value = KV_REPEAT;
        else it.value = KV_SPARE;
        it.stamp = next_stamp();
      end
      send_item(it);
      pace();
      if (it.command == CMD_QUERY || it.is_key) done++;
    end
  endtask

  initial begin
    bit [STAMP_W-1:0] stamp;
    bit [GAP_LIMIT_W-1:0] limits [6];
    model = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_gap_limit({6'h3F, GAP_LIMIT_RESET});

    query_beat();
    send_item('{command: CMD_KEY, is_key: 1'b0, code: 10'd30, value: KV_PRESS, stamp: '1});
    stamp = 48'd1000;
    key_beat(10'd30, KV_PRESS, stamp);
    key_beat(10'd30, KV_PRESS, stamp);
    stamp = stamp + STAMP_W'(GAP_LIMIT_RESET) - STAMP_W'(1);
    key_beat(10'd767, KV_PRESS, stamp);
    stamp = stamp + STAMP_W'(GAP_LIMIT_RESET);
    key_beat(10'd256, KV_PRESS, stamp);
    key_beat(CODE_CTRL_L, KV_PRESS, stamp + 10);
    key_beat(10'd30, KV_PRESS, stamp + 20);
    key_beat(CODE_SHIFT_L, KV_PRESS, stamp + 30);
    key_beat(CODE_CTRL_L, KV_RELEASE, stamp + 35);
    key_beat(CODE_ALT_R, KV_REPEAT, stamp + 36);
    key_beat(10'd255, KV_PRESS, stamp + 40);
    key_beat(CODE_ALT_L, KV_SPARE, stamp + 41);
    key_beat(CODE_CTRL_R, KV_SPARE, stamp + 42);
    key_beat(CODE_ALT_R, KV_RELEASE, stamp + 43);
    key_beat(10'd0, KV_PRESS, stamp + 50);
    key_beat(CODE_CTRL_R, KV_RELEASE, stamp + 55);
    key_beat(10'd0, KV_PRESS, stamp + 60);
    key_beat(10'd0, KV_REPEAT, stamp + 61);
    key_beat(10'd1, KV_PRESS, '1);
    key_beat(10'd1, KV_PRESS, 48'd3);
    key_beat(10'd2, KV_PRESS, 48'd3);
    query_beat();
    send_item('{command: CMD_QUERY, is_key: 1'b1, code: 10'd767, value: KV_SPARE, stamp: '1});
    now_us = 48'd3;

    limits = '{'0, 26'd1, GAP_LIMIT_MAX, 26'($urandom_range(1, GAP_LIMIT_MAX)),
               26'($urandom_range(1000, 500000)), GAP_LIMIT_RESET};
    for (int p = 0; p < 6; p++) begin
      settle();
      steady = (p == 2);
      write_gap_limit({6'($urandom()), limits[p]});
      run_typing(ITEMS_PER_PHASE);
    end
    steady = 1'b0;

    settle();
    if (model.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kse_pkg.sv
rtl/kse_div.sv
rtl/kse_ctrl.sv
rtl/kse_datapath.sv
rtl/keypress_statistics_engine.sv
rtl/kse_checker.sv
tb/tb_keypress_statistics_engine.sv
